>>> src/combined_lcg_shuffle_prng_core_macros.svh
// Assertion macros shared by the generator RTL.
`ifndef COMBINED_LCG_SHUFFLE_PRNG_CORE_MACROS_SVH
`define COMBINED_LCG_SHUFFLE_PRNG_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CLSPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clspr assertion failed");

// Next-cycle implication, disabled while in reset.
`define CLSPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clspr assertion failed");

`endif

>>> src/clspr_pkg.sv
// Package: constants, types and state codes of the combined LCG shuffle generator.
`default_nettype none

package clspr_pkg;

  localparam int unsigned VAL_W = 31;

  // Generator moduli and multipliers.
  localparam logic [31:0] MOD1  = 32'd2147483563;
  localparam logic [31:0] MOD2  = 32'd2147483399;
  localparam logic [15:0] MULT1 = 16'd40014;
  localparam logic [15:0] MULT2 = 16'd40692;

  // 2^31 mod MODx, used to fold the upper product bits back in.
  localparam logic [7:0] FOLD1 = 8'd85;
  localparam logic [7:0] FOLD2 = 8'd249;

  localparam logic [31:0] OUT_MAX = MOD1 - 32'd1;

  localparam logic [VAL_W-1:0] FIRST_RESET  = 31'd1;
  localparam logic [VAL_W-1:0] SECOND_RESET = 31'd123456789;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 32;
  localparam int unsigned WARMUP_EXTRA        = 8;

  // Shift used by the reciprocal slot estimate.
  localparam int unsigned RECIP_SHIFT = 40;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM_MUL,
    ST_WARM_FOLD,
    ST_WARM_RED,
    ST_DRAW_MUL,
    ST_DRAW_FOLD,
    ST_DRAW_READ,
    ST_DRAW_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic load_seed;
    logic cnt_load;
    logic cnt_dec;
    logic mul;
    logic fold;
    logic red_first;
    logic red_second;
    logic warm_write;
    logic set_last;
    logic slot_read;
    logic out_commit;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> src/clspr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module clspr_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/clspr_datapath.sv
// Datapath: modular multipliers, slot divider, shuffle table and output register.
`default_nettype none

module clspr_datapath
  import clspr_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dp_cmd_t          cmd_i,
  output dp_sts_t               sts_o,
  input  wire logic [VAL_W-1:0] seed_value_i,
  output logic      [VAL_W-1:0] rand_o
);

`include "combined_lcg_shuffle_prng_core_macros.svh"

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned QW = AW + 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + WARMUP_EXTRA);
  localparam int unsigned MW = VAL_W + 16;

  localparam logic [63:0] SLOT_DIV_W = 64'd1 + 64'(OUT_MAX) / 64'(TABLE_DEPTH);
  localparam logic [31:0] SLOT_DIV   = SLOT_DIV_W[31:0];
  localparam logic [63:0] RECIP_W64  = (64'd1 << RECIP_SHIFT) / SLOT_DIV_W;
  localparam int unsigned RECIP_W    = $clog2(RECIP_W64 + 64'd1);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_W64);
  localparam int unsigned PW = VAL_W + RECIP_W;

  // generator state
  logic [VAL_W-1:0] first_q, first_d;
  logic [VAL_W-1:0] second_q, second_d;
  logic [VAL_W-1:0] last_q, last_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic             rd_valid_q;

  // pipeline payload
  logic [MW-1:0]    p1_q, p2_q;
  logic [PW-1:0]    ps_q;
  logic [31:0]      s1_q, s2_q;
  logic [QW-1:0]    qest_q;
  logic [31:0]      rem_q;
  logic [AW-1:0]    slot_q;
  logic [VAL_W-1:0] rand_q;

  logic [VAL_W-1:0] seed_fix;
  logic [VAL_W-1:0] first_new, second_new;
  logic [QW-1:0]    qest_c;
  logic [31:0]      rem_c;
  logic [QW:0]      slot_full;
  logic [AW-1:0]    slot_c;
  logic             warm_we;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [VAL_W-1:0] ram_rdata;
  logic [VAL_W-1:0] tbl_val;
  logic [31:0]      diff;
  logic [31:0]      diff_adj;

  assign seed_fix = (seed_value_i == '0) ? VAL_W'(1) : seed_value_i;

  // final conditional subtract of the folded products
  assign first_new  = (s1_q >= MOD1) ? VAL_W'(s1_q - MOD1) : s1_q[VAL_W-1:0];
  assign second_new = (s2_q >= MOD2) ? VAL_W'(s2_q - MOD2) : s2_q[VAL_W-1:0];

  // slot = last / SLOT_DIV: reciprocal estimate, then one correction step
  assign qest_c = QW'(ps_q >> RECIP_SHIFT);
  assign rem_c  = 32'(last_q) - 32'(qest_c) * SLOT_DIV;

  always_comb begin
    slot_full = (QW + 1)'(qest_q) + ((rem_q >= SLOT_DIV) ? (QW + 1)'(1) : (QW + 1)'(0));
    if (slot_full >= (QW + 1)'(TABLE_DEPTH)) begin
      slot_c = AW'(TABLE_DEPTH - 1);
    end else begin
      slot_c = slot_full[AW-1:0];
    end
  end

  assign warm_we   = cmd_i.warm_write && (cnt_q < CW'(TABLE_DEPTH));
  assign ram_we    = warm_we || cmd_i.out_commit;
  assign ram_waddr = cmd_i.out_commit ? slot_q : cnt_q[AW-1:0];
  assign ram_wdata = cmd_i.out_commit ? first_q : first_new;

  clspr_ram #(
    .WIDTH(VAL_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.slot_read),
    .raddr_i(slot_c),
    .rdata_o(ram_rdata)
  );

  // never-written slots read as zero
  assign tbl_val  = rd_valid_q ? ram_rdata : '0;
  assign diff     = {1'b0, tbl_val} - {1'b0, second_q};
  assign diff_adj = (diff[31] || (diff == '0)) ? diff + OUT_MAX : diff;

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    valid_d  = valid_q;
    if (cmd_i.load_seed) begin
      first_d  = seed_fix;
      second_d = seed_fix;
    end
    if (cmd_i.red_first) begin
      first_d = first_new;
    end
    if (cmd_i.red_second) begin
      second_d = second_new;
    end
    if (cmd_i.set_last) begin
      last_d = first_new;
    end
    if (cmd_i.out_commit) begin
      last_d = diff_adj[VAL_W-1:0];
    end
    if (cmd_i.cnt_load) begin
      cnt_d = CW'(TABLE_DEPTH + WARMUP_EXTRA - 1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
    if (ram_we) begin
      valid_d[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= FIRST_RESET;
      second_q   <= SECOND_RESET;
      last_q     <= '0;
      cnt_q      <= '0;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
      last_q   <= last_d;
      cnt_q    <= cnt_d;
      valid_q  <= valid_d;
      if (cmd_i.slot_read) begin
        rd_valid_q <= valid_q[slot_c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p1_q <= MW'(first_q) * MW'(MULT1);
      p2_q <= MW'(second_q) * MW'(MULT2);
      ps_q <= PW'(last_q) * PW'(RECIP);
    end
    if (cmd_i.fold) begin
      // 2^31 == FOLDx (mod MODx)
      s1_q   <= 32'(p1_q[VAL_W-1:0]) + 32'(p1_q[MW-1:VAL_W]) * 32'(FOLD1);
      s2_q   <= 32'(p2_q[VAL_W-1:0]) + 32'(p2_q[MW-1:VAL_W]) * 32'(FOLD2);
      qest_q <= qest_c;
      rem_q  <= rem_c;
    end
    if (cmd_i.slot_read) begin
      slot_q <= slot_c;
    end
    if (cmd_i.out_commit) begin
      rand_q <= diff_adj[VAL_W-1:0];
    end
  end

  assign sts_o.cnt_zero = (cnt_q == '0);
  assign rand_o         = rand_q;

  `CLSPR_ASSERT_NEXT(a_first_reduced, clk_i, rst_ni, cmd_i.red_first, 32'(first_q) < MOD1)
  `CLSPR_ASSERT_NEXT(a_second_reduced, clk_i, rst_ni, cmd_i.red_second, 32'(second_q) < MOD2)
  `CLSPR_ASSERT_NEXT(a_out_range, clk_i, rst_ni, cmd_i.out_commit, (rand_q != '0) && (32'(rand_q) <= OUT_MAX))

endmodule

`default_nettype wire

>>> src/clspr_ctrl.sv
// Controller: sequences warm-up steps and draws, owns the handshakes.
`default_nettype none

module clspr_ctrl
  import clspr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire logic    func_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output dp_cmd_t      cmd_o,
  input  wire dp_sts_t sts_i
);

`include "combined_lcg_shuffle_prng_core_macros.svh"

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        ready;
  logic        in_accept;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_accept = in_valid_i && ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = func_i ? ST_WARM_MUL : ST_DRAW_MUL;
        end
      end
      ST_WARM_MUL:  state_d = ST_WARM_FOLD;
      ST_WARM_FOLD: state_d = ST_WARM_RED;
      ST_WARM_RED: begin
        state_d = sts_i.cnt_zero ? ST_DRAW_MUL : ST_WARM_MUL;
      end
      ST_DRAW_MUL:  state_d = ST_DRAW_FOLD;
      ST_DRAW_FOLD: state_d = ST_DRAW_READ;
      ST_DRAW_READ: state_d = ST_DRAW_OUT;
      ST_DRAW_OUT: begin
        if (out_free) begin
          if (in_accept) begin
            state_d = func_i ? ST_WARM_MUL : ST_DRAW_MUL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    ready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        ready = 1'b1;
      end
      ST_WARM_MUL:  cmd_o.mul = 1'b1;
      ST_WARM_FOLD: cmd_o.fold = 1'b1;
      ST_WARM_RED: begin
        cmd_o.red_first  = 1'b1;
        cmd_o.warm_write = 1'b1;
        cmd_o.set_last   = sts_i.cnt_zero;
        cmd_o.cnt_dec    = !sts_i.cnt_zero;
      end
      ST_DRAW_MUL:  cmd_o.mul = 1'b1;
      ST_DRAW_FOLD: cmd_o.fold = 1'b1;
      ST_DRAW_READ: begin
        cmd_o.red_first  = 1'b1;
        cmd_o.red_second = 1'b1;
        cmd_o.slot_read  = 1'b1;
      end
      ST_DRAW_OUT: begin
        ready            = out_free;
        cmd_o.out_commit = out_free;
      end
      default: begin
        ready = 1'b0;
      end
    endcase
    if (in_valid_i && ready && func_i) begin
      cmd_o.load_seed = 1'b1;
      cmd_o.cnt_load  = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = !ready;
  assign out_valid_o = out_valid_q;

  `CLSPR_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, out_valid_q && out_stall_i, !cmd_o.out_commit)
  `CLSPR_ASSERT_NEXT(a_warm_to_draw, clk_i, rst_ni, (state_q == ST_WARM_RED) && sts_i.cnt_zero, state_q == ST_DRAW_MUL)
  `CLSPR_ASSERT_IMPL(a_seed_on_reseed, clk_i, rst_ni, in_accept, cmd_o.load_seed == func_i)

endmodule

`default_nettype wire

>>> src/combined_lcg_shuffle_prng_core.sv
// Top level of the combined LCG random generator with shuffle table.
//
// Uniform random generator combining two multiplicative congruential
// generators (moduli 2147483563 and 2147483399) through a shuffle table of
// TABLE_DEPTH entries. A request with func_i low draws the next number; a
// request with func_i high reseeds from seed_value_i (zero acts as one), runs
// TABLE_DEPTH+8 warm-up steps that fill the table, then draws. Every request
// returns one random_value_o in 1..2147483562; divide by 2147483563 for a
// uniform real. The next request is taken in the cycle the result is
// registered, so a new request is never taken while one is in progress.
// In a reseed each warm-up step goes through the shared multiply, fold
// and reduce stages of the first generator in turn. Table entries never
// written since reset read as zero. Both channels use valid/stall; the
// result sits in an output register, so a stalled result does not lose
// any state.
`default_nettype none

module combined_lcg_shuffle_prng_core
  import clspr_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // request channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             func_i,
  input  wire logic [VAL_W-1:0] seed_value_i,
  // result channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [VAL_W-1:0] random_value_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing and handshakes
  clspr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // generators, slot divider, table and result register
  clspr_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .seed_value_i(seed_value_i),
    .rand_o      (random_value_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking bench for the combined LCG shuffle generator.
`timescale 1ns / 1ps

module testbench
  import clspr_pkg::*;
();

  localparam int unsigned DEPTH = DEFAULT_TABLE_DEPTH;

  // request codes carried on func_i
  localparam logic FUNC_DRAW   = 1'b0;
  localparam logic FUNC_RESEED = 1'b1;

  // slot selection divides the previous output into DEPTH bands
  localparam int unsigned SLOT_DIV   = 1 + OUT_MAX / DEPTH;
  localparam longint      OUT_MAX_L  = OUT_MAX;

  // reseed is the slowest request; the drain waits a little beyond it
  localparam int unsigned DRAIN_CYCLES = 3 * (DEPTH + WARMUP_EXTRA) + 20;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 10;

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             func         = FUNC_DRAW;
  logic [VAL_W-1:0] seed_value   = '0;
  logic             out_stall    = 1'b0;
  wire              in_stall;
  wire              out_valid;
  wire  [VAL_W-1:0] random_value;

  // shadow copy of the generator state
  logic [VAL_W-1:0] gen_first;
  logic [VAL_W-1:0] gen_second;
  logic [VAL_W-1:0] last_value;
  logic [VAL_W-1:0] shuffle_slots [DEPTH];

  logic [VAL_W-1:0] expected_values [$];

  // idling controls, shared between the stimulus and the result sink
  bit tx_gaps_on  = 1'b0;
  bit rx_gaps_on  = 1'b0;
  bit rx_hold_req = 1'b0;

  int unsigned n_requests = 0;
  int unsigned n_reseeds  = 0;
  int unsigned n_results  = 0;
  int unsigned n_faults   = 0;

  combined_lcg_shuffle_prng_core #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (func),
    .seed_value_i  (seed_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .random_value_o(random_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // one multiplicative congruential step, exact product modulo the modulus
  function automatic logic [VAL_W-1:0] lcg_advance(input logic [VAL_W-1:0] x,
                                                   input logic [15:0] mult,
                                                   input logic [31:0] modulus);
    logic [63:0] prod;
    logic [63:0] rem;
    prod = {33'd0, x} * {48'd0, mult};
    rem  = prod % {32'd0, modulus};
    return rem[VAL_W-1:0];
  endfunction

  // advances the shadow state by one request and returns the value it yields
  function automatic logic [VAL_W-1:0] predict_random_value(input logic f,
                                                            input logic [VAL_W-1:0] seed);
    int          i;
    int unsigned slot;
    longint      picked;
    longint      diff;
    if (f == FUNC_RESEED) begin
      // zero seed acts as one; seeds past a modulus fold on the first step
      gen_first  = (seed == '0) ? 31'd1 : seed;
      gen_second = gen_first;
      for (i = DEPTH + WARMUP_EXTRA - 1; i >= 0; i--) begin
        gen_first = lcg_advance(gen_first, MULT1, MOD1);
        if (i < DEPTH) shuffle_slots[i] = gen_first;
      end
      last_value = shuffle_slots[0];
    end
    gen_first  = lcg_advance(gen_first, MULT1, MOD1);
    gen_second = lcg_advance(gen_second, MULT2, MOD2);
    slot = last_value / SLOT_DIV;
    if (slot >= DEPTH) slot = DEPTH - 1;
    picked = shuffle_slots[slot];
    diff   = picked - longint'(gen_second);
    shuffle_slots[slot] = gen_first;
    if (diff < 1) diff = diff + OUT_MAX_L;
    last_value = diff[VAL_W-1:0];
    return last_value;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: called at a rising edge, returns at the edge that took it
  // ---------------------------------------------------------------------------

  task automatic send_request(input logic f, input logic [VAL_W-1:0] seed);
    int unsigned gap;
    gap = 0;
    if (tx_gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    seed_value <= seed;
    // inputs settle by the falling edge; acceptance follows at the next rise
    @(negedge clk);
    while (in_stall) @(negedge clk);
    expected_values.push_back(predict_random_value(f, seed));
    n_requests++;
    if (f == FUNC_RESEED) n_reseeds++;
    @(posedge clk);
  endtask

  // seeds spread over the whole range, with extra weight near both moduli and near zero
  function automatic logic [VAL_W-1:0] pick_seed();
    logic [31:0] s;
    case ($urandom_range(0, 9))
      0:       s = MOD1 - 32'd3 + $urandom_range(0, 6);
      1:       s = MOD2 - 32'd3 + $urandom_range(0, 6);
      2:       s = $urandom_range(0, 15);
      default: s = $urandom();
    endcase
    return s[VAL_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report_fault(input string what, input logic [VAL_W-1:0] want,
                              input logic [VAL_W-1:0] got);
    if (n_faults < MAX_REPORTS)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    n_faults++;
  endtask

  initial begin : result_sink
    int unsigned burst;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        // long hold-off so the block backs up into its request port
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_check
    logic [VAL_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_values.size() == 0) begin
        report_fault("result with no request outstanding", '0, random_value);
      end else begin
        want = expected_values.pop_front();
        if (random_value !== want) report_fault("random_value mismatch", want, random_value);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // draws straight out of reset read a table of zeros
  task automatic test_draw_from_reset();
    repeat (3) send_request(FUNC_DRAW, $urandom());
  endtask

  // zero seed, seeds at and below each modulus and above MOD1, the top seed; one draw after each
  task automatic test_seed_extremes();
    logic [31:0] seeds [10];
    int          k;
    seeds = '{32'd0, 32'd1, MOD2 - 32'd1, MOD2, MOD1 - 32'd1, MOD1, MOD1 + 32'd1,
              32'h7FFF_FFFF, 32'd123456789, 32'd2};
    for (k = 0; k < 10; k++) begin
      send_request(FUNC_RESEED, seeds[k][VAL_W-1:0]);
      send_request(FUNC_DRAW, ~seeds[k][VAL_W-1:0]);
    end
  endtask

  // streams of draws broken up by reseeds, idling switched per segment
  task automatic test_random_streams(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if (k % 50 == 0) begin
        tx_gaps_on = ($urandom_range(0, 2) != 0);
        rx_gaps_on = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 99) < 8) send_request(FUNC_RESEED, pick_seed());
      else                           send_request(FUNC_DRAW, $urandom());
    end
  endtask

  // receiver holds off while draws keep coming back to back
  task automatic test_output_backpressure(input int unsigned count);
    tx_gaps_on  = 1'b0;
    rx_gaps_on  = 1'b0;
    rx_hold_req = 1'b1;
    repeat (count) send_request(FUNC_DRAW, $urandom());
  endtask

  // no idling at all: requests at full rate, one reseed in the middle
  task automatic test_full_rate_tail(input int unsigned count);
    int unsigned k;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    for (k = 0; k < count; k++)
      send_request((k == count / 2) ? FUNC_RESEED : FUNC_DRAW, $urandom());
  endtask

  initial begin
    gen_first  = FIRST_RESET;
    gen_second = SECOND_RESET;
    last_value = '0;
    foreach (shuffle_slots[i]) shuffle_slots[i] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_draw_from_reset();
    test_seed_extremes();
    test_random_streams(540);
    test_output_backpressure(25);
    test_full_rate_tail(60);
    in_valid <= 1'b0;

    while (expected_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d requests (%0d reseeds incl. zero, modulus-edge and top seeds),",
             n_requests, n_reseeds);
    $display("summary: %0d results compared under random and %0d-cycle hold-off, %0d faults",
             n_results, HOLD_CYCLES, n_faults);
    if (n_faults == 0 && expected_values.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
